// ===== design/assert_macros.svh =====
// Assertion macros used by the window sender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/gbn_pkg.sv =====
// Package with the types, constants and codes of the window sender.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  // Field and register widths.
  localparam int SEQ_W      = 24;
  localparam int TMO_W      = 20;
  localparam int WIN_CFG_W  = 7;
  localparam int MAX_WINDOW = 64;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int UNIT_W     = SEQ_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOTAL   = 2'd2;

  // Register values after reset.
  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET  = 7'd64;
  localparam logic [TMO_W-1:0]     TIMEOUT_RESET = 20'd100000;
  localparam logic [SEQ_W-1:0]     TOTAL_RESET   = 24'd0;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_ACK   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_ACK2,
    ST_UPD,
    ST_OUTS,
    ST_ROOM,
    ST_FIN,
    ST_SEND,
    ST_EMPTY
  } state_t;

  // Operations of the shared adder.
  typedef enum logic {
    UOP_SUB,
    UOP_INC
  } unit_op_t;

  typedef struct packed {
    unit_op_t          op;
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] res;
    logic              ge;
  } unit_rsp_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [WIN_CFG_W-1:0] win_limit;
    logic [TMO_W-1:0]     timeout_ticks;
    logic [SEQ_W-1:0]     total_packets;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/gbn_ifs.sv =====
// Valid/ready channel interfaces for the command and send items.
`timescale 1ns / 1ps
`default_nettype none

interface gbn_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [gbn_pkg::SEQ_W-1:0]  ack_num;
  logic                       ack_ok;

  modport source (output valid, output func, output ack_num, output ack_ok, input ready);
  modport sink (input valid, input func, input ack_num, input ack_ok, output ready);
endinterface

interface gbn_out_if;
  logic                       valid;
  logic                       ready;
  logic [gbn_pkg::SEQ_W-1:0]  send_seq;
  logic                       send_valid;
  logic                       is_retransmit;
  logic                       transfer_done;
  logic                       last;

  modport source (
    output valid, output send_seq, output send_valid, output is_retransmit,
    output transfer_done, output last, input ready
  );
  modport sink (
    input valid, input send_seq, input send_valid, input is_retransmit,
    input transfer_done, input last, output ready
  );
endinterface

`default_nettype wire

// ===== design/gbn_unit.sv =====
// Shared adder: subtract with compare flag, or increment.
`timescale 1ns / 1ps
`default_nettype none

module gbn_unit (
  input  gbn_pkg::unit_req_t req,
  output gbn_pkg::unit_rsp_t rsp
);

  logic [gbn_pkg::UNIT_W-1:0] b_term;
  logic [gbn_pkg::UNIT_W:0]   sum;

  // Subtract is a + ~b + 1; increment is a + 0 + 1.
  assign b_term = (req.op == gbn_pkg::UOP_SUB) ? ~req.b : '0;
  assign sum    = {1'b0, req.a} + {1'b0, b_term} + {{gbn_pkg::UNIT_W{1'b0}}, 1'b1};

  // Carry out of the subtract means a >= b.
  assign rsp.res = sum[gbn_pkg::UNIT_W-1:0];
  assign rsp.ge  = sum[gbn_pkg::UNIT_W];

endmodule

`default_nettype wire

// ===== design/gbn_ctrl.sv =====
// Sequencer, window state and output register of the window sender.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gbn_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  gbn_pkg::cfg_t    cfg,
  gbn_in_if.sink           cmd,
  gbn_out_if.source        snd
);

  gbn_pkg::state_t state;
  gbn_pkg::state_t state_next;

  // Latched item.
  gbn_pkg::func_t              func_code;
  logic [gbn_pkg::SEQ_W-1:0]   ack_val;
  logic                        ack_good;

  // Window and timer state.
  logic [gbn_pkg::SEQ_W-1:0]   window_base;
  logic [gbn_pkg::SEQ_W-1:0]   next_seq;
  logic                        timer_running;
  logic [gbn_pkg::TMO_W-1:0]   timer_count;

  // Per-item work.
  logic                        do_resend;
  logic                        do_restart;
  logic [gbn_pkg::CNT_W-1:0]   outstanding;
  logic [gbn_pkg::CNT_W-1:0]   rem_total;
  logic [gbn_pkg::CNT_W-1:0]   rem_retx;
  logic [gbn_pkg::SEQ_W-1:0]   cur_seq;
  logic                        done;

  // Output register.
  logic                        out_valid;
  logic [gbn_pkg::SEQ_W-1:0]   out_seq;
  logic                        out_send;
  logic                        out_retx;
  logic                        out_done;
  logic                        out_last;

  gbn_pkg::unit_req_t          ureq;
  gbn_pkg::unit_rsp_t          ursp;
  logic                        load;

  // Fill sizing.
  logic [gbn_pkg::CNT_W-1:0]   eff_win;
  logic [gbn_pkg::CNT_W:0]     room_win;
  logic [gbn_pkg::CNT_W-1:0]   room_total;
  logic [gbn_pkg::CNT_W-1:0]   n_fill;
  logic [gbn_pkg::CNT_W-1:0]   n_resend;
  logic [gbn_pkg::CNT_W:0]     n_sum;

  gbn_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  assign cmd.ready = (state == gbn_pkg::ST_IDLE) && !rst;

  // The output register takes a result when it is empty or being drained.
  assign load = ((state == gbn_pkg::ST_SEND) || (state == gbn_pkg::ST_EMPTY)) &&
                (!out_valid || snd.ready);

  // Effective window: zero acts as one, large values clip to the maximum.
  always_comb begin
    if (cfg.win_limit == '0) begin
      eff_win = gbn_pkg::CNT_W'(1);
    end else if (cfg.win_limit > gbn_pkg::WIN_CFG_W'(gbn_pkg::MAX_WINDOW)) begin
      eff_win = gbn_pkg::CNT_W'(gbn_pkg::MAX_WINDOW);
    end else begin
      eff_win = gbn_pkg::CNT_W'(cfg.win_limit);
    end
  end

  // New packets allowed: the smaller of window room and packets left.
  always_comb begin
    room_win = {1'b0, eff_win} - {1'b0, outstanding};
    if (|ursp.res[gbn_pkg::SEQ_W-1:gbn_pkg::CNT_W]) begin
      room_total = '1;
    end else begin
      room_total = ursp.res[gbn_pkg::CNT_W-1:0];
    end
    if (!ursp.ge || room_win[gbn_pkg::CNT_W] || (room_win == '0)) begin
      n_fill = '0;
    end else if (room_win[gbn_pkg::CNT_W-1:0] < room_total) begin
      n_fill = room_win[gbn_pkg::CNT_W-1:0];
    end else begin
      n_fill = room_total;
    end
    n_resend = do_resend ? outstanding : '0;
    n_sum    = {1'b0, n_resend} + {1'b0, n_fill};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gbn_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = gbn_pkg::ST_EVENT;
      end
      gbn_pkg::ST_EVENT: begin
        case (func_code)
          gbn_pkg::FUNC_TICK: begin
            if (timer_running && !ursp.ge) state_next = gbn_pkg::ST_UPD;
            else state_next = gbn_pkg::ST_OUTS;
          end
          gbn_pkg::FUNC_ACK: begin
            if (ack_good && ursp.ge) state_next = gbn_pkg::ST_ACK2;
            else state_next = gbn_pkg::ST_OUTS;
          end
          default: state_next = gbn_pkg::ST_OUTS;
        endcase
      end
      gbn_pkg::ST_ACK2: begin
        if (ursp.ge) state_next = gbn_pkg::ST_OUTS;
        else state_next = gbn_pkg::ST_UPD;
      end
      gbn_pkg::ST_UPD:  state_next = gbn_pkg::ST_OUTS;
      gbn_pkg::ST_OUTS: state_next = gbn_pkg::ST_ROOM;
      gbn_pkg::ST_ROOM: state_next = gbn_pkg::ST_FIN;
      gbn_pkg::ST_FIN: begin
        if (rem_total != '0) state_next = gbn_pkg::ST_SEND;
        else state_next = gbn_pkg::ST_EMPTY;
      end
      gbn_pkg::ST_SEND: begin
        if (load && (rem_total == gbn_pkg::CNT_W'(1))) state_next = gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_EMPTY: begin
        if (load) state_next = gbn_pkg::ST_IDLE;
      end
      default: state_next = gbn_pkg::ST_IDLE;
    endcase
  end

  // Shared adder operands for each step.
  always_comb begin
    ureq.op = gbn_pkg::UOP_SUB;
    ureq.a  = '0;
    ureq.b  = '0;
    case (state)
      gbn_pkg::ST_EVENT: begin
        if (func_code == gbn_pkg::FUNC_TICK) begin
          ureq.a = gbn_pkg::UNIT_W'(timer_count);
          ureq.b = gbn_pkg::UNIT_W'(cfg.timeout_ticks);
        end else begin
          ureq.a = gbn_pkg::UNIT_W'(ack_val);
          ureq.b = gbn_pkg::UNIT_W'(window_base);
        end
      end
      gbn_pkg::ST_ACK2: begin
        ureq.a = gbn_pkg::UNIT_W'(ack_val);
        ureq.b = gbn_pkg::UNIT_W'(next_seq);
      end
      gbn_pkg::ST_UPD: begin
        ureq.op = gbn_pkg::UOP_INC;
        if (func_code == gbn_pkg::FUNC_TICK) ureq.a = gbn_pkg::UNIT_W'(timer_count);
        else ureq.a = gbn_pkg::UNIT_W'(ack_val);
      end
      gbn_pkg::ST_OUTS: begin
        ureq.a = gbn_pkg::UNIT_W'(next_seq);
        ureq.b = gbn_pkg::UNIT_W'(window_base);
      end
      gbn_pkg::ST_ROOM: begin
        ureq.a = gbn_pkg::UNIT_W'(cfg.total_packets);
        ureq.b = gbn_pkg::UNIT_W'(next_seq);
      end
      gbn_pkg::ST_FIN: begin
        ureq.a = gbn_pkg::UNIT_W'(window_base);
        ureq.b = gbn_pkg::UNIT_W'(cfg.total_packets);
      end
      gbn_pkg::ST_SEND: begin
        ureq.op = gbn_pkg::UOP_INC;
        ureq.a  = gbn_pkg::UNIT_W'(cur_seq);
      end
      default: begin
        ureq.op = gbn_pkg::UOP_SUB;
      end
    endcase
  end

  // Window, timer and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gbn_pkg::ST_IDLE;
      window_base   <= '0;
      next_seq      <= '0;
      timer_running <= 1'b0;
      timer_count   <= '0;
      do_resend     <= 1'b0;
      do_restart    <= 1'b0;
      rem_total     <= '0;
      rem_retx      <= '0;
    end else begin
      state <= state_next;
      case (state)
        gbn_pkg::ST_IDLE: begin
          if (cmd.valid) begin
            func_code  <= gbn_pkg::func_t'(cmd.func);
            ack_val    <= cmd.ack_num;
            ack_good   <= cmd.ack_ok;
            do_resend  <= 1'b0;
            do_restart <= 1'b0;
          end
        end
        gbn_pkg::ST_EVENT: begin
          case (func_code)
            gbn_pkg::FUNC_START: begin
              window_base   <= '0;
              next_seq      <= '0;
              timer_running <= 1'b0;
              timer_count   <= '0;
            end
            gbn_pkg::FUNC_TICK: begin
              // Timeout: resend the window and restart the count.
              if (timer_running && ursp.ge) begin
                do_resend   <= 1'b1;
                timer_count <= '0;
              end
            end
            gbn_pkg::FUNC_ACK: begin
              // Corrupt or stale ack resends from the base.
              if (!(ack_good && ursp.ge)) begin
                do_resend  <= 1'b1;
                do_restart <= 1'b1;
              end
            end
            default: begin
              do_resend <= 1'b0;
            end
          endcase
        end
        gbn_pkg::ST_UPD: begin
          if (func_code == gbn_pkg::FUNC_TICK) begin
            timer_count <= ursp.res[gbn_pkg::TMO_W-1:0];
          end else begin
            window_base <= ursp.res[gbn_pkg::SEQ_W-1:0];
            do_restart  <= 1'b1;
          end
        end
        gbn_pkg::ST_OUTS: begin
          // The window never holds more than the maximum, so the count is narrow.
          outstanding <= ursp.res[gbn_pkg::CNT_W-1:0];
          if (do_restart) begin
            timer_count   <= '0;
            timer_running <= (ursp.res[gbn_pkg::SEQ_W-1:0] != '0);
          end
        end
        gbn_pkg::ST_ROOM: begin
          rem_total <= n_sum[gbn_pkg::CNT_W-1:0];
          rem_retx  <= n_resend;
          cur_seq   <= do_resend ? window_base : next_seq;
          // Sending the packet at the base starts the timer.
          if ((n_fill != '0) && (outstanding == '0)) begin
            timer_running <= 1'b1;
            timer_count   <= '0;
          end
        end
        gbn_pkg::ST_FIN: begin
          done <= ursp.ge;
        end
        gbn_pkg::ST_SEND: begin
          if (load) begin
            cur_seq   <= ursp.res[gbn_pkg::SEQ_W-1:0];
            rem_total <= rem_total - gbn_pkg::CNT_W'(1);
            if (rem_retx != '0) rem_retx <= rem_retx - gbn_pkg::CNT_W'(1);
            if (rem_total == gbn_pkg::CNT_W'(1)) begin
              next_seq <= ursp.res[gbn_pkg::SEQ_W-1:0];
            end
          end
        end
        default: begin
          do_restart <= do_restart;
        end
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (snd.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      if (state == gbn_pkg::ST_SEND) begin
        out_seq  <= cur_seq;
        out_send <= 1'b1;
        out_retx <= (rem_retx != '0);
        out_last <= (rem_total == gbn_pkg::CNT_W'(1));
      end else begin
        out_seq  <= '0;
        out_send <= 1'b0;
        out_retx <= 1'b0;
        out_last <= 1'b1;
      end
      out_done <= done;
    end
  end

  assign snd.valid         = out_valid;
  assign snd.send_seq      = out_seq;
  assign snd.send_valid    = out_send;
  assign snd.is_retransmit = out_retx;
  assign snd.transfer_done = out_done;
  assign snd.last          = out_last;

  // Checks on the window and the send loop.
  `ASSERT_CLK(a_base_not_past_next, window_base <= next_seq,
    "window base passed next sequence")
  `ASSERT_CLK(a_window_bounded,
    (next_seq - window_base) <= gbn_pkg::SEQ_W'(gbn_pkg::MAX_WINDOW), "window too large")
  `ASSERT_CLK(a_retx_within_total, rem_retx <= rem_total, "more resends pending than sends")
  `ASSERT_CLK(a_last_ends_item,
    (load && (state == gbn_pkg::ST_SEND) && (rem_total == gbn_pkg::CNT_W'(1))) |=>
    (state == gbn_pkg::ST_IDLE && rem_total == '0), "last send did not end the item")
  `ASSERT_ALWAYS(a_idle_no_work, (state == gbn_pkg::ST_IDLE) |-> (rem_total == '0),
    "idle with sends pending")

endmodule

`default_nettype wire

// ===== design/go_back_n_window_sender.sv =====
// Top level of the go-back-N window sender: configuration registers and sequencer.
//
// Usage: items arrive on the cmd channel (func, ack_num, ack_ok) with a
// valid/ready handshake; func 0 starts a transfer, 1 is a timer tick and
// 2 an acknowledgement. Each item yields a run of send items on the snd
// channel, one per cycle while the receiver does not stall, the final one
// marked by last; an item that sends nothing yields a single item with
// send_valid low. The window limit, timeout and packet-total registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Flow: cmd.ready is high only between items. After acceptance the
// sequencer runs the event and window sizing steps, all on one shared
// 25-bit adder, then presents one send item per cycle while the receiver
// does not stall. Results pass through an output register; if the
// receiver stalls the send loop holds in place, and a new item is
// accepted while the last result of the previous one still waits.
// Reset (rst, synchronous) clears the window, the timer and the output
// register, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_window_sender (
  input  wire                                clk,
  input  wire                                rst,
  gbn_in_if.sink                             cmd,
  gbn_out_if.source                          snd,
  input  wire                                cfg_we,
  input  wire [gbn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [gbn_pkg::CFG_DATA_W-1:0]      cfg_data
);

  gbn_pkg::cfg_t cfg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_limit     <= gbn_pkg::WINDOW_RESET;
      cfg.timeout_ticks <= gbn_pkg::TIMEOUT_RESET;
      cfg.total_packets <= gbn_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::CFG_IDX_WINDOW:  cfg.win_limit     <= cfg_data[gbn_pkg::WIN_CFG_W-1:0];
        gbn_pkg::CFG_IDX_TIMEOUT: cfg.timeout_ticks <= cfg_data[gbn_pkg::TMO_W-1:0];
        gbn_pkg::CFG_IDX_TOTAL:   cfg.total_packets <= cfg_data[gbn_pkg::SEQ_W-1:0];
        default: cfg <= cfg;
      endcase
    end
  end

  gbn_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .snd (snd)
  );

endmodule

`default_nettype wire
